/* sv/zctb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctb_pkg: shared types and constants of the tone-to-byte decoder
// Register map, field widths and reset values used by the front, the back
// and the top level.
// ----------------------------------------------------------------------------
package zctb_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int RATE_W     = 18;
	localparam int LEN_CFG_W  = 13;
	localparam int FREQ_W     = 25;
	localparam int BYTE_W     = 8;
	localparam int XING_W     = 12;

	// Chunks shorter than this are cut but never produce a byte.
	localparam int MIN_CHUNK  = 10;

	// Shift-subtract divider operands: the mapping numerator is
	// diff*510+span (34 bits) and its divisor 2*span (26 bits).
	localparam int MAP_NUM_W  = 34;
	localparam int DIV_DVS_W  = 26;

	// Job queue between front and back.
	localparam int JOB_DEPTH  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_CHUNK_LEN   = 3'd1,
		REG_BASE_FREQ   = 3'd2,
		REG_SPAN_FREQ   = 3'd3,
		REG_MIN_ACCEPT  = 3'd4,
		REG_MAX_ACCEPT  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [RATE_W-1:0]    sample_rate_hz;
		logic [LEN_CFG_W-1:0] chunk_length;
		logic [FREQ_W-1:0]    base_freq_q8;
		logic [FREQ_W-1:0]    span_freq_q8;
		logic [FREQ_W-1:0]    min_accept_q8;
		logic [FREQ_W-1:0]    max_accept_q8;
	} cfg_regs_t;

	localparam logic [RATE_W-1:0]    RST_SAMPLE_RATE = 18'd44100;
	localparam logic [LEN_CFG_W-1:0] RST_CHUNK_LEN   = 13'd2205;
	localparam logic [FREQ_W-1:0]    RST_BASE_FREQ   = 25'd56320;
	localparam logic [FREQ_W-1:0]    RST_SPAN_FREQ   = 25'd512000;
	localparam logic [FREQ_W-1:0]    RST_MIN_ACCEPT  = 25'd51200;
	localparam logic [FREQ_W-1:0]    RST_MAX_ACCEPT  = 25'd768000;

endpackage

/* sv/zctb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctb_front: sample intake and crossing counter
// Counts sign changes inside each chunk and, at the end of a chunk that can
// produce a byte, hands the crossing count and chunk length to the back.
// ----------------------------------------------------------------------------
module zctb_front #(
	parameter int MAX_CHUNK   = 4096,
	parameter int SAMPLE_BITS = 16,
	localparam int CNT_W = $clog2(MAX_CHUNK),
	localparam int LEN_W = $clog2(MAX_CHUNK + 1),
	localparam int JOB_W = CNT_W + LEN_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic [zctb_pkg::LEN_CFG_W-1:0]      chunk_length,
	output logic                                job_push,
	input  logic                                job_full,
	output logic [JOB_W-1:0]                    job_data
);

	localparam int CMP_W = (LEN_W > zctb_pkg::LEN_CFG_W) ? LEN_W : zctb_pkg::LEN_CFG_W;

	logic             prev_neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pos_q;

	logic [CMP_W-1:0] len_ext;
	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] pos_inc;
	logic [CNT_W-1:0] cnt_next;
	logic             neg;
	logic             crossing;
	logic             chunk_end;
	logic             accept;

	always_comb begin
		len_ext = CMP_W'(chunk_length);
		if (len_ext > CMP_W'(MAX_CHUNK)) begin
			eff_len = LEN_W'(MAX_CHUNK);
		end else if (len_ext == '0) begin
			eff_len = LEN_W'(1);
		end else begin
			eff_len = LEN_W'(len_ext);
		end
	end

	assign neg       = sample[SAMPLE_BITS-1];
	assign crossing  = (pos_q != '0) && (neg != prev_neg_q);
	assign cnt_next  = cnt_q + CNT_W'(crossing);
	assign pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
	assign chunk_end = pos_inc >= eff_len;

	// Only the beat that closes a chunk needs room in the job queue.
	assign full      = chunk_end && job_full;
	assign accept    = push && !full;

	assign job_push  = accept && chunk_end && (eff_len >= LEN_W'(zctb_pkg::MIN_CHUNK))
		&& (cnt_next != '0);
	assign job_data  = {cnt_next, eff_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_neg_q <= 1'b0;
			cnt_q      <= '0;
			pos_q      <= '0;
		end else if (accept) begin
			prev_neg_q <= neg;
			if (chunk_end) begin
				cnt_q <= '0;
				pos_q <= '0;
			end else begin
				cnt_q <= cnt_next;
				pos_q <= CNT_W'(pos_inc);
			end
		end
	end

`ifndef ASSERT_OFF
	// Each sample adds at most one crossing, and the first sample of a chunk adds none.
	a_cnt_below_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) || (cnt_q < pos_q))
		else $error("crossing count ran ahead of chunk position");

	a_job_ends_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (pos_q == '0) && (cnt_q == '0))
		else $error("job issued without closing the chunk");

	a_job_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into a full queue");
`endif

endmodule

/* sv/zctb_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctb_job_fifo: short job queue between front and back
// Holds finished chunks (crossing count and length) until the back takes them.
// ----------------------------------------------------------------------------
module zctb_job_fifo #(
	parameter int W = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         valid
);

	localparam int PTR_W = $clog2(zctb_pkg::JOB_DEPTH);
	localparam int CNT_W = $clog2(zctb_pkg::JOB_DEPTH + 1);

	logic [W-1:0]     mem_q [zctb_pkg::JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == CNT_W'(zctb_pkg::JOB_DEPTH);
	assign valid   = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* sv/zctb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctb_back: frequency estimate and byte mapping
// Takes one chunk at a time, divides crossings*rate*128 by the chunk length,
// checks the acceptance window, maps the frequency onto a byte (0 below base,
// 255 above base plus span, else by a second pass through the same divider)
// and presents the result in an output register.
module zctb_back #(
	parameter int MAX_CHUNK = 4096,
	localparam int CNT_W = $clog2(MAX_CHUNK),
	localparam int LEN_W = $clog2(MAX_CHUNK + 1),
	localparam int JOB_W = CNT_W + LEN_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_pop,
	input  logic [JOB_W-1:0]                  job_data,
	input  zctb_pkg::cfg_regs_t               cfg,
	output logic                              empty,
	input  logic                              pop,
	output logic [zctb_pkg::BYTE_W-1:0]       byte_value,
	output logic [zctb_pkg::FREQ_W-1:0]       tone_freq_q8,
	output logic [zctb_pkg::XING_W-1:0]       crossing_total
);

	localparam int PROD_W = CNT_W + zctb_pkg::RATE_W;
	localparam int NUM1_W = PROD_W + 7;
	localparam int DVD_W  = (NUM1_W > zctb_pkg::MAP_NUM_W) ? NUM1_W : zctb_pkg::MAP_NUM_W;
	localparam int DVS_W  = zctb_pkg::DIV_DVS_W;
	localparam int IT_W   = $clog2(DVD_W);
	localparam int FW     = zctb_pkg::FREQ_W;
	localparam int BW     = zctb_pkg::BYTE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_CHECK,
		S_PREP,
		S_DIV2,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [IT_W-1:0]  it_q;
	logic [CNT_W-1:0] cross_q;
	logic [FW-1:0]    f_q;
	logic [FW-1:0]    diff_q;
	logic [BW-1:0]    byte_q;
	logic             out_valid_q;
	logic [BW-1:0]    out_byte_q;
	logic [FW-1:0]    out_freq_q;
	logic [CNT_W-1:0] out_cross_q;

	logic [CNT_W-1:0]             job_cross;
	logic [LEN_W-1:0]             job_len;
	logic [PROD_W-1:0]            prod;
	logic [DVS_W:0]               trial;
	logic                         ge;
	logic [DVS_W-1:0]             rem_next;
	logic [DVD_W-1:0]             dvd_next;
	logic                         last_it;
	logic                         emit;
	logic [DVS_W-1:0]             upper;
	logic [zctb_pkg::MAP_NUM_W-1:0] map_num;
	logic                         out_load;

	assign job_cross = job_data[JOB_W-1:LEN_W];
	assign job_len   = job_data[LEN_W-1:0];
	assign prod      = PROD_W'(job_cross) * PROD_W'(cfg.sample_rate_hz);
	assign job_pop   = (state_q == S_IDLE) && job_valid;

	// One restoring step: one quotient bit per cycle, shifted into the dividend.
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_next = ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
	assign dvd_next = {dvd_q[DVD_W-2:0], ge};
	assign last_it  = it_q == IT_W'(DVD_W - 1);

	assign emit  = (dvd_q != '0) && (dvd_q >= DVD_W'(cfg.min_accept_q8))
		&& (dvd_q <= DVD_W'(cfg.max_accept_q8));
	assign upper = DVS_W'(cfg.base_freq_q8) + DVS_W'(cfg.span_freq_q8);

	// diff*510 + span, with 510 taken as 512 - 2.
	assign map_num = {diff_q, 9'd0} - zctb_pkg::MAP_NUM_W'({diff_q, 1'b0})
		+ zctb_pkg::MAP_NUM_W'(cfg.span_freq_q8);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						dvd_q   <= DVD_W'({prod, 7'd0});
						dvs_q   <= DVS_W'(job_len);
						rem_q   <= '0;
						it_q    <= '0;
						cross_q <= job_cross;
						state_q <= S_DIV1;
					end
				end
				S_DIV1, S_DIV2: begin
					dvd_q <= dvd_next;
					rem_q <= rem_next;
					it_q  <= it_q + IT_W'(1);
					if (last_it) begin
						if (state_q == S_DIV2) begin
							byte_q  <= dvd_next[BW-1:0];
							state_q <= S_OUT;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					f_q    <= dvd_q[FW-1:0];
					diff_q <= dvd_q[FW-1:0] - cfg.base_freq_q8;
					if (!emit) begin
						state_q <= S_IDLE;
					end else if (dvd_q < DVD_W'(cfg.base_freq_q8)) begin
						byte_q  <= '0;
						state_q <= S_OUT;
					end else if (dvd_q > DVD_W'(upper)) begin
						byte_q  <= '1;
						state_q <= S_OUT;
					end else if (cfg.span_freq_q8 == '0) begin
						byte_q  <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					dvd_q   <= DVD_W'(map_num);
					dvs_q   <= DVS_W'({cfg.span_freq_q8, 1'b0});
					rem_q   <= '0;
					it_q    <= '0;
					state_q <= S_DIV2;
				end
				S_OUT: begin
					if (out_load) begin
						out_byte_q  <= byte_q;
						out_freq_q  <= f_q;
						out_cross_q <= cross_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty          = !out_valid_q;
	assign byte_value     = out_byte_q;
	assign tone_freq_q8   = out_freq_q;
	assign crossing_total = zctb_pkg::XING_W'(out_cross_q);

`ifndef ASSERT_OFF
	a_no_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV1) || (state_q == S_DIV2)) |-> (dvs_q != '0))
		else $error("divider running with a zero divisor");

	a_map_fits_byte: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV2) && last_it) |-> (dvd_next[DVD_W-1:BW] == '0))
		else $error("byte mapping quotient exceeds eight bits");

	a_out_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (tone_freq_q8 != '0) && (tone_freq_q8 >= cfg.min_accept_q8)
			&& (tone_freq_q8 <= cfg.max_accept_q8))
		else $error("result outside the acceptance window");
`endif

endmodule

/* sv/zero_crossing_tone_to_byte.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_crossing_tone_to_byte: zero-crossing tone decoder
// Cuts a sample stream into chunks, estimates each chunk's tone frequency
// from its sign changes and turns accepted frequencies into bytes.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while full is low. A byte beat appears for
// each chunk of at least MIN_CHUNK samples whose estimated frequency is
// nonzero and inside the acceptance window; other chunks produce nothing.
// The back end takes one chunk at a time: one pass of a one-bit-per-cycle
// shift-subtract divider gives the frequency and, after a window check, a
// second pass maps frequencies between base and base plus span onto a byte.
// A two-entry job queue sits between the sample counter and the back end, so
// input runs at one sample per cycle while the queue has room; full rises on
// the sample that closes a chunk while two jobs wait. The configuration port
// is always ready; registers should be written only while no results are
// outstanding. Index values past the last register are ignored.
// ----------------------------------------------------------------------------
module zero_crossing_tone_to_byte #(
	parameter int MAX_CHUNK   = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [zctb_pkg::BYTE_W-1:0]          byte_value,
	output logic [zctb_pkg::FREQ_W-1:0]          tone_freq_q8,
	output logic [zctb_pkg::XING_W-1:0]          crossing_total,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [zctb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [zctb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(MAX_CHUNK);
	localparam int LEN_W = $clog2(MAX_CHUNK + 1);
	localparam int JOB_W = CNT_W + LEN_W;

	zctb_pkg::cfg_regs_t cfg_q;

	logic             job_push;
	logic             job_full;
	logic [JOB_W-1:0] job_wdata;
	logic             job_valid;
	logic             job_pop;
	logic [JOB_W-1:0] job_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_rate_hz <= zctb_pkg::RST_SAMPLE_RATE;
			cfg_q.chunk_length   <= zctb_pkg::RST_CHUNK_LEN;
			cfg_q.base_freq_q8   <= zctb_pkg::RST_BASE_FREQ;
			cfg_q.span_freq_q8   <= zctb_pkg::RST_SPAN_FREQ;
			cfg_q.min_accept_q8  <= zctb_pkg::RST_MIN_ACCEPT;
			cfg_q.max_accept_q8  <= zctb_pkg::RST_MAX_ACCEPT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (zctb_pkg::cfg_index_t'(cfg_index))
				zctb_pkg::REG_SAMPLE_RATE:
					cfg_q.sample_rate_hz <= cfg_data[zctb_pkg::RATE_W-1:0];
				zctb_pkg::REG_CHUNK_LEN:
					cfg_q.chunk_length <= cfg_data[zctb_pkg::LEN_CFG_W-1:0];
				zctb_pkg::REG_BASE_FREQ:
					cfg_q.base_freq_q8 <= cfg_data[zctb_pkg::FREQ_W-1:0];
				zctb_pkg::REG_SPAN_FREQ:
					cfg_q.span_freq_q8 <= cfg_data[zctb_pkg::FREQ_W-1:0];
				zctb_pkg::REG_MIN_ACCEPT:
					cfg_q.min_accept_q8 <= cfg_data[zctb_pkg::FREQ_W-1:0];
				zctb_pkg::REG_MAX_ACCEPT:
					cfg_q.max_accept_q8 <= cfg_data[zctb_pkg::FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	zctb_front #(
		.MAX_CHUNK   (MAX_CHUNK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.chunk_length (cfg_q.chunk_length),
		.job_push     (job_push),
		.job_full     (job_full),
		.job_data     (job_wdata)
	);

	zctb_job_fifo #(
		.W (JOB_W)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job_wdata),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_rdata),
		.valid   (job_valid)
	);

	zctb_back #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job_pop        (job_pop),
		.job_data       (job_rdata),
		.cfg            (cfg_q),
		.empty          (empty),
		.pop            (pop),
		.byte_value     (byte_value),
		.tone_freq_q8   (tone_freq_q8),
		.crossing_total (crossing_total)
	);

endmodule
